>>> design/alc_pkg.sv
// ----------------------------------------------------------------------------
// alc_pkg : shared definitions for the address lookup cache
// result codes, action codes and default sizes
// ----------------------------------------------------------------------------
package alc_pkg;

    // default sizes
    localparam int DEF_INDEX_BITS = 8;
    localparam int DEF_ID_BITS    = 16;
    localparam int DEF_ADDR_BITS  = 32;
    localparam int DEF_COUNT_BITS = 16;
    localparam int DEF_NUM_BINS   = 3;

    // fixed field widths
    localparam int KIND_BITS   = 2;
    localparam int TARGET_BITS = 2;
    localparam int BINNUM_BITS = 2;

    // most results one transaction can cause, and the width of a result count
    localparam int MAX_RESULTS = 3;
    localparam int RCNT_BITS   = 2;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_REPLY     = 2'd0,
        KIND_FETCH     = 2'd1,
        KIND_BIN_REPLY = 2'd2,
        KIND_REJECT    = 2'd3
    } kind_t;

    typedef enum logic {
        ACT_LOOKUP = 1'b0,
        ACT_UPDATE = 1'b1
    } action_t;

endpackage

>>> design/alc_ram.sv
// ----------------------------------------------------------------------------
// alc_ram : generic single-port-write, single-port-read ram
// one write and one registered read per cycle, read returns old data
// ----------------------------------------------------------------------------
module alc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/address_lookup_cache_with_miss_bins_unit.sv
// ----------------------------------------------------------------------------
// address_lookup_cache_with_miss_bins_unit : kernel id to address cache
// direct-mapped table with a small set of miss bins and one parked lookup
// ----------------------------------------------------------------------------
// A lookup (action 0) is answered from a direct-mapped table indexed by the
// low INDEX_BITS of the kernel id; on a miss it joins a busy bin waiting for
// the same id, claims the lowest free bin (slow-fetch request, then reply)
// or, with every bin busy, is parked, after which lookups are rejected until
// an update frees a bin. An update (action 1) to a valid bin writes the
// fetched address for the bin's stored id, frees the bin, returns a bin reply
// with the forwarded count and then serves the parked lookup. A transaction
// gives zero to three result transactions; m_last marks the final one.
// Timing: after reset the table is cleared, one entry a cycle, with s_ready
// low. After that a transaction is taken every cycle as long as each gives at
// most one result and m_ready stays high; one with more results holds the
// single result port until each is taken, and the input stalls meanwhile.
// The table read starts at acceptance, so results are ready in the cycle
// after acceptance and move to m_ once the result set register is free.
// ----------------------------------------------------------------------------
module address_lookup_cache_with_miss_bins_unit #(
    parameter int INDEX_BITS = alc_pkg::DEF_INDEX_BITS,
    parameter int ID_BITS    = alc_pkg::DEF_ID_BITS,
    parameter int ADDR_BITS  = alc_pkg::DEF_ADDR_BITS,
    parameter int COUNT_BITS = alc_pkg::DEF_COUNT_BITS,
    parameter int NUM_BINS   = alc_pkg::DEF_NUM_BINS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input transactions
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_action,
    input  logic [ID_BITS-1:0]                 s_kernel_id,
    input  logic [alc_pkg::BINNUM_BITS-1:0]    s_bin_number,
    input  logic [ADDR_BITS-1:0]               s_fetched_address,
    // result transactions
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [alc_pkg::KIND_BITS-1:0]      m_kind,
    output logic [alc_pkg::TARGET_BITS-1:0]    m_target,
    output logic [ADDR_BITS-1:0]               m_address_out,
    output logic [ID_BITS-1:0]                 m_id_out,
    output logic [COUNT_BITS-1:0]              m_forward_count,
    output logic                               m_waiting,
    output logic                               m_bad_update,
    output logic                               m_last
);

    localparam int TAG_BITS   = ID_BITS - INDEX_BITS;
    localparam int ENTRY_BITS = TAG_BITS + ADDR_BITS;
    localparam int DEPTH      = 1 << INDEX_BITS;
    localparam int NRES       = alc_pkg::MAX_RESULTS;
    localparam int RCB        = alc_pkg::RCNT_BITS;
    localparam int TGB        = alc_pkg::TARGET_BITS;

    // ------------------------------------------------------------------
    // declarations
    // ------------------------------------------------------------------
    // table clearing pass after reset
    logic                  clr_active_reg;
    logic [INDEX_BITS-1:0] clr_idx_reg;

    // input register
    logic                            in_valid_reg;
    alc_pkg::action_t                in_action_reg;
    logic [ID_BITS-1:0]              in_id_reg;
    logic [alc_pkg::BINNUM_BITS-1:0] in_bn_reg;
    logic [ADDR_BITS-1:0]            in_fa_reg;

    // table read bypass for a write at the same edge as the read
    logic                  byp_hit_reg;
    logic [ENTRY_BITS-1:0] byp_data_reg;

    // bins and parked lookup
    logic [NUM_BINS-1:0]   bin_busy_reg, bin_busy_next;
    logic [ID_BITS-1:0]    bin_id_reg    [NUM_BINS];
    logic [ID_BITS-1:0]    bin_id_next   [NUM_BINS];
    logic [COUNT_BITS-1:0] bin_count_reg [NUM_BINS];
    logic [COUNT_BITS-1:0] bin_count_next[NUM_BINS];
    logic                  parked_valid_reg, parked_valid_next;
    logic [ID_BITS-1:0]    parked_id_reg, parked_id_next;
    logic                  sticky_reg, sticky_next;

    // result set register, slot 0 is on the port
    alc_pkg::kind_t        res_kind_reg [NRES];
    logic [TGB-1:0]        res_tgt_reg  [NRES];
    logic [ADDR_BITS-1:0]  res_addr_reg [NRES];
    logic [ID_BITS-1:0]    res_id_reg   [NRES];
    logic [COUNT_BITS-1:0] res_cnt_f_reg[NRES];
    logic [RCB-1:0]        res_cnt_reg;
    logic                  res_wait_reg;
    logic                  res_bad_reg;

    // results computed for the transaction in the input register
    alc_pkg::kind_t        rn_kind [NRES];
    logic [TGB-1:0]        rn_tgt  [NRES];
    logic [ADDR_BITS-1:0]  rn_addr [NRES];
    logic [ID_BITS-1:0]    rn_id   [NRES];
    logic [COUNT_BITS-1:0] rn_cnt  [NRES];
    logic [RCB-1:0]        rn_num;

    // handshakes
    logic s_accept, m_accept, out_free, process_en;

    // table access
    logic                  ram_we, ram_we_proc;
    logic [INDEX_BITS-1:0] ram_waddr, wr_idx;
    logic [ENTRY_BITS-1:0] ram_wdata, wr_data, ram_rdata, entry;
    logic [TAG_BITS-1:0]   ent_tag, in_tag;
    logic [ADDR_BITS-1:0]  ent_addr;

    // bin search
    logic [NUM_BINS-1:0]   match_oh, free_oh, sel_oh, refill_oh, busy_after;
    logic [TGB-1:0]        match_tgt, free_tgt, refill_tgt;
    logic [ID_BITS-1:0]    upd_id;
    logic [COUNT_BITS-1:0] upd_count, match_count;
    logic                  bin_ok, hit;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign m_valid    = (res_cnt_reg != '0);
    assign m_accept   = m_valid && m_ready;
    // the result set register can take a new set this cycle
    assign out_free   = (res_cnt_reg == '0) || ((res_cnt_reg == RCB'(1)) && m_ready);
    assign process_en = in_valid_reg && out_free;
    assign s_ready    = !clr_active_reg && (!in_valid_reg || out_free);
    assign s_accept   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // clearing pass
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end else if (clr_active_reg) begin
            clr_idx_reg <= clr_idx_reg + INDEX_BITS'(1);
            if (clr_idx_reg == '1) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_action_reg <= alc_pkg::action_t'(s_action);
            in_id_reg     <= s_kernel_id;
            in_bn_reg     <= s_bin_number;
            in_fa_reg     <= s_fetched_address;
        end
    end

    // ------------------------------------------------------------------
    // lookup table, read started as the transaction is taken
    // ------------------------------------------------------------------
    assign ram_we    = clr_active_reg || ram_we_proc;
    assign ram_waddr = clr_active_reg ? clr_idx_reg : wr_idx;
    assign ram_wdata = clr_active_reg ? '0 : wr_data;

    alc_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (s_kernel_id[INDEX_BITS-1:0]),
        .rdata (ram_rdata)
    );

    // the ram returns old data when an update writes the entry being read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_hit_reg <= 1'b0;
        end else if (s_accept) begin
            byp_hit_reg <= ram_we_proc && (wr_idx == s_kernel_id[INDEX_BITS-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            byp_data_reg <= wr_data;
        end
    end

    assign entry    = byp_hit_reg ? byp_data_reg : ram_rdata;
    assign ent_tag  = entry[ENTRY_BITS-1:ADDR_BITS];
    assign ent_addr = entry[ADDR_BITS-1:0];
    assign in_tag   = in_id_reg[ID_BITS-1:INDEX_BITS];
    // an all-zero entry never hits
    assign hit      = (ent_tag == in_tag) && ((ent_tag != '0) || (ent_addr != '0));

    // ------------------------------------------------------------------
    // bin search, lowest bin wins everywhere
    // ------------------------------------------------------------------
    always_comb begin
        match_oh    = '0;
        free_oh     = '0;
        refill_oh   = '0;
        match_tgt   = '0;
        free_tgt    = '0;
        refill_tgt  = '0;
        upd_id      = '0;
        upd_count   = '0;
        match_count = '0;
        for (int b = 0; b < NUM_BINS; b++) begin
            sel_oh[b] = (int'(in_bn_reg) == b + 1);
        end
        busy_after = bin_busy_reg & ~sel_oh;
        for (int b = NUM_BINS - 1; b >= 0; b--) begin
            if (bin_busy_reg[b] && (bin_id_reg[b] == in_id_reg)) begin
                match_oh    = '0;
                match_oh[b] = 1'b1;
                match_tgt   = TGB'(b + 1);
                match_count = bin_count_reg[b];
            end
            if (!bin_busy_reg[b]) begin
                free_oh    = '0;
                free_oh[b] = 1'b1;
                free_tgt   = TGB'(b + 1);
            end
            if (!busy_after[b]) begin
                refill_oh    = '0;
                refill_oh[b] = 1'b1;
                refill_tgt   = TGB'(b + 1);
            end
            if (sel_oh[b]) begin
                upd_id    = bin_id_reg[b];
                upd_count = bin_count_reg[b];
            end
        end
        bin_ok = |sel_oh;
    end

    // ------------------------------------------------------------------
    // transaction processing
    // ------------------------------------------------------------------
    always_comb begin
        bin_busy_next     = bin_busy_reg;
        bin_id_next       = bin_id_reg;
        bin_count_next    = bin_count_reg;
        parked_valid_next = parked_valid_reg;
        parked_id_next    = parked_id_reg;
        sticky_next       = sticky_reg;
        for (int r = 0; r < NRES; r++) begin
            rn_kind[r] = alc_pkg::KIND_REPLY;
            rn_tgt[r]  = '0;
            rn_addr[r] = '0;
            rn_id[r]   = '0;
            rn_cnt[r]  = '0;
        end
        rn_num      = '0;
        ram_we_proc = 1'b0;
        wr_idx      = upd_id[INDEX_BITS-1:0];
        wr_data     = {upd_id[ID_BITS-1:INDEX_BITS], in_fa_reg};

        if (in_action_reg == alc_pkg::ACT_LOOKUP) begin
            if (parked_valid_reg) begin
                // rejected while a lookup is parked
                rn_kind[0] = alc_pkg::KIND_REJECT;
                rn_num     = RCB'(1);
            end else if (hit) begin
                rn_addr[0] = ent_addr;
                rn_num     = RCB'(1);
            end else if (|match_oh) begin
                // forwarded onto a bin already waiting for this id
                for (int b = 0; b < NUM_BINS; b++) begin
                    if (match_oh[b] && (match_count != '1)) begin
                        bin_count_next[b] = match_count + COUNT_BITS'(1);
                    end
                end
                rn_tgt[0]  = match_tgt;
                rn_addr[0] = ent_addr;
                rn_num     = RCB'(1);
            end else if (|free_oh) begin
                // new bin: slow-fetch request then reply
                for (int b = 0; b < NUM_BINS; b++) begin
                    if (free_oh[b]) begin
                        bin_busy_next[b]  = 1'b1;
                        bin_id_next[b]    = in_id_reg;
                        bin_count_next[b] = COUNT_BITS'(1);
                    end
                end
                rn_kind[0] = alc_pkg::KIND_FETCH;
                rn_tgt[0]  = free_tgt;
                rn_id[0]   = in_id_reg;
                rn_tgt[1]  = free_tgt;
                rn_addr[1] = ent_addr;
                rn_num     = RCB'(2);
            end else begin
                // all bins busy: park, no result
                parked_valid_next = 1'b1;
                parked_id_next    = in_id_reg;
            end
        end else begin
            if (!bin_ok) begin
                sticky_next = 1'b1;
            end else begin
                ram_we_proc   = 1'b1;
                bin_busy_next = busy_after;
                rn_kind[0]    = alc_pkg::KIND_BIN_REPLY;
                rn_tgt[0]     = in_bn_reg;
                rn_addr[0]    = in_fa_reg;
                rn_cnt[0]     = upd_count;
                rn_num        = RCB'(1);
                // serve the parked lookup from the lowest free bin
                if (parked_valid_reg) begin
                    parked_valid_next = 1'b0;
                    for (int b = 0; b < NUM_BINS; b++) begin
                        if (refill_oh[b]) begin
                            bin_busy_next[b]  = 1'b1;
                            bin_id_next[b]    = parked_id_reg;
                            bin_count_next[b] = COUNT_BITS'(1);
                        end
                    end
                    rn_kind[1] = alc_pkg::KIND_FETCH;
                    rn_tgt[1]  = refill_tgt;
                    rn_id[1]   = parked_id_reg;
                    rn_tgt[2]  = refill_tgt;
                    rn_num     = RCB'(3);
                end
            end
        end

        if (!process_en) begin
            ram_we_proc = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // state registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_busy_reg     <= '0;
            parked_valid_reg <= 1'b0;
            parked_id_reg    <= '0;
            sticky_reg       <= 1'b0;
            for (int b = 0; b < NUM_BINS; b++) begin
                bin_id_reg[b]    <= '0;
                bin_count_reg[b] <= '0;
            end
        end else if (process_en) begin
            bin_busy_reg     <= bin_busy_next;
            bin_id_reg       <= bin_id_next;
            bin_count_reg    <= bin_count_next;
            parked_valid_reg <= parked_valid_next;
            parked_id_reg    <= parked_id_next;
            sticky_reg       <= sticky_next;
        end
    end

    // ------------------------------------------------------------------
    // result set register, shifts one slot per result transaction
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_cnt_reg <= '0;
        end else if (process_en) begin
            res_cnt_reg <= rn_num;
        end else if (m_accept) begin
            res_cnt_reg <= res_cnt_reg - RCB'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (process_en) begin
            res_kind_reg  <= rn_kind;
            res_tgt_reg   <= rn_tgt;
            res_addr_reg  <= rn_addr;
            res_id_reg    <= rn_id;
            res_cnt_f_reg <= rn_cnt;
            res_wait_reg  <= parked_valid_next;
            res_bad_reg   <= sticky_next;
        end else if (m_accept) begin
            for (int r = 0; r < NRES - 1; r++) begin
                res_kind_reg[r]  <= res_kind_reg[r+1];
                res_tgt_reg[r]   <= res_tgt_reg[r+1];
                res_addr_reg[r]  <= res_addr_reg[r+1];
                res_id_reg[r]    <= res_id_reg[r+1];
                res_cnt_f_reg[r] <= res_cnt_f_reg[r+1];
            end
        end
    end

    assign m_kind          = res_kind_reg[0];
    assign m_target        = res_tgt_reg[0];
    assign m_address_out   = res_addr_reg[0];
    assign m_id_out        = res_id_reg[0];
    assign m_forward_count = res_cnt_f_reg[0];
    assign m_waiting       = res_wait_reg;
    assign m_bad_update    = res_bad_reg;
    assign m_last          = (res_cnt_reg == RCB'(1));

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`ifndef SYNTH
    // no transaction enters while the table is being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s_ready)
        else $error("transaction taken during table clear");

    // a lookup is parked only when every bin is busy
    a_parked_all_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        parked_valid_reg |-> (&bin_busy_reg))
        else $error("parked lookup with a free bin");

    // a lookup seen while parked gives exactly one reject
    a_reject_while_parked: assert property (@(posedge aclk) disable iff (!aresetn)
        (process_en && (in_action_reg == alc_pkg::ACT_LOOKUP) && parked_valid_reg)
        |=> (m_valid && (m_kind == alc_pkg::KIND_REJECT) && m_last))
        else $error("lookup while parked not rejected");

    // a slow-fetch request is always followed by its reply
    a_fetch_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == alc_pkg::KIND_FETCH)) |-> !m_last)
        else $error("slow-fetch request without following reply");

    // update writes never collide with the clearing pass
    a_no_write_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we_proc |-> !clr_active_reg)
        else $error("table update during clear");
`endif

endmodule
